// ===== rtl/core/min_queue_two_stacks_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the min queue top level.
// They sample on clk and are disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MIN_QUEUE_TWO_STACKS_TOP_ASSERT_SVH
`define MIN_QUEUE_TWO_STACKS_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define MQTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define MQTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mqts_pkg.sv =====
// ----------------------------------------------------------------------------
// mqts_pkg
// Sizes, codes and the stack entry type of the min queue.
// ----------------------------------------------------------------------------
`default_nettype none

package mqts_pkg;

  localparam int STACK_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 12;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_PEEK  = 2'd2,
    OP_CLEAR = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] minimum;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/min_queue_two_stacks_top.sv =====
// Flow: an accepted beat goes to S_FINISH, which offers the result; a pop that
// leaves entries on the outbound stack passes S_RELOAD first. A pop or peek
// that finds the outbound stack empty first moves the inbound stack, through
// S_XFER_RD and S_XFER_WR for each entry, then S_FRONT. No new beat is accepted
// until the state is back in S_IDLE; S_FINISH waits while out_stall holds a result.
// Reset clears both counts at once; the stack memories are not cleared.
// ----------------------------------------------------------------------------
// min_queue_two_stacks_top
// FIFO with running minimum built from an inbound and an outbound stack.
// ----------------------------------------------------------------------------
`default_nettype none

module min_queue_two_stacks_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            opcode,
  input  logic signed [mqts_pkg::DATA_W-1:0]    push_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mqts_pkg::DATA_W-1:0]    front_value,
  output logic signed [mqts_pkg::DATA_W-1:0]    queue_minimum,
  output logic [mqts_pkg::COUNT_W-1:0]          entry_count,
  output logic                                  is_empty,
  output logic [1:0]                            status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_XFER_RD,
    S_XFER_WR,
    S_FRONT,
    S_RELOAD,
    S_FINISH
  } state_t;

  state_t state;

  logic [mqts_pkg::CNT_W-1:0]         in_count;
  logic [mqts_pkg::CNT_W-1:0]         out_count;
  logic signed [mqts_pkg::DATA_W-1:0] in_top_min;
  logic signed [mqts_pkg::DATA_W-1:0] out_top_value;
  logic signed [mqts_pkg::DATA_W-1:0] out_top_min;
  logic signed [mqts_pkg::DATA_W-1:0] front;
  mqts_pkg::status_t                  result_status;
  logic                               pend_pop;

  mqts_pkg::opcode_t                  op;
  logic                               in_fire;
  logic                               in_full;
  logic                               front_go;
  logic                               pop_now;
  logic [mqts_pkg::CNT_W-1:0]         in_dec;
  logic [mqts_pkg::CNT_W-1:0]         out_dec;
  logic [mqts_pkg::CNT_W-1:0]         out_dec2;
  logic signed [mqts_pkg::DATA_W-1:0] push_min;
  logic signed [mqts_pkg::DATA_W-1:0] xfer_min;
  logic signed [mqts_pkg::DATA_W-1:0] min_now;
  logic [mqts_pkg::CNT_W:0]           total;

  logic                               in_we;
  logic                               in_re;
  mqts_pkg::entry_t                   in_wdata;
  mqts_pkg::entry_t                   in_rdata;
  logic                               out_we;
  logic                               out_re;
  mqts_pkg::entry_t                   out_wdata;
  mqts_pkg::entry_t                   out_rdata;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && (state == S_IDLE);
  assign op       = mqts_pkg::opcode_t'(opcode);
  assign in_full  = (in_count == mqts_pkg::CNT_W'(mqts_pkg::STACK_DEPTH));
  assign in_dec   = in_count - 1'b1;
  assign out_dec  = out_count - 1'b1;
  assign out_dec2 = out_count - 2'd2;

  always_comb begin
    front_go = (state == S_FRONT) ||
               (in_fire && (op == mqts_pkg::OP_POP || op == mqts_pkg::OP_PEEK) &&
                out_count != '0);
    pop_now  = (state == S_IDLE) ? (op == mqts_pkg::OP_POP) : pend_pop;
    push_min = (in_count != '0 && in_top_min < push_value) ? in_top_min : push_value;
    xfer_min = (out_count != '0 && out_top_min < in_rdata.value) ?
               out_top_min : in_rdata.value;
    if (in_count != '0 && out_count != '0) begin
      min_now = (in_top_min < out_top_min) ? in_top_min : out_top_min;
    end else if (in_count != '0) begin
      min_now = in_top_min;
    end else if (out_count != '0) begin
      min_now = out_top_min;
    end else begin
      min_now = '0;
    end
    total = {1'b0, in_count} + {1'b0, out_count};
  end

  assign in_we             = in_fire && (op == mqts_pkg::OP_PUSH) && !in_full;
  assign in_wdata.value    = push_value;
  assign in_wdata.minimum  = push_min;
  assign in_re             = (state == S_XFER_RD);
  assign out_we            = (state == S_XFER_WR);
  assign out_wdata.value   = in_rdata.value;
  assign out_wdata.minimum = xfer_min;
  assign out_re            = front_go && pop_now && (out_count > mqts_pkg::CNT_W'(1));

  mqts_ram #(
    .DEPTH(mqts_pkg::STACK_DEPTH),
    .WIDTH($bits(mqts_pkg::entry_t))
  ) u_in_ram (
    .clk  (clk),
    .we   (in_we),
    .waddr(in_count[mqts_pkg::ADDR_W-1:0]),
    .wdata(in_wdata),
    .re   (in_re),
    .raddr(in_dec[mqts_pkg::ADDR_W-1:0]),
    .rdata(in_rdata)
  );

  mqts_ram #(
    .DEPTH(mqts_pkg::STACK_DEPTH),
    .WIDTH($bits(mqts_pkg::entry_t))
  ) u_out_ram (
    .clk  (clk),
    .we   (out_we),
    .waddr(out_count[mqts_pkg::ADDR_W-1:0]),
    .wdata(out_wdata),
    .re   (out_re),
    .raddr(out_dec2[mqts_pkg::ADDR_W-1:0]),
    .rdata(out_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_count  <= '0;
      out_count <= '0;
      out_valid <= 1'b0;
      pend_pop  <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            pend_pop <= (op == mqts_pkg::OP_POP);
            unique case (op)
              mqts_pkg::OP_PUSH: begin
                front <= '0;
                if (in_full) begin
                  result_status <= mqts_pkg::STATUS_FULL;
                end else begin
                  result_status <= mqts_pkg::STATUS_OK;
                  in_count      <= in_count + 1'b1;
                  in_top_min    <= push_min;
                end
                state <= S_FINISH;
              end
              mqts_pkg::OP_POP, mqts_pkg::OP_PEEK: begin
                if (in_count == '0 && out_count == '0) begin
                  front         <= '0;
                  result_status <= mqts_pkg::STATUS_EMPTY;
                  state         <= S_FINISH;
                end else if (out_count == '0) begin
                  state <= S_XFER_RD;
                end else begin
                  front         <= out_top_value;
                  result_status <= mqts_pkg::STATUS_OK;
                  if (pop_now) begin
                    out_count <= out_dec;
                    state     <= out_re ? S_RELOAD : S_FINISH;
                  end else begin
                    state <= S_FINISH;
                  end
                end
              end
              mqts_pkg::OP_CLEAR: begin
                front         <= '0;
                result_status <= mqts_pkg::STATUS_OK;
                in_count      <= '0;
                out_count     <= '0;
                state         <= S_FINISH;
              end
              default: begin
                front         <= '0;
                result_status <= mqts_pkg::STATUS_OK;
                state         <= S_FINISH;
              end
            endcase
          end
        end
        S_XFER_RD: begin
          in_count <= in_dec;
          state    <= S_XFER_WR;
        end
        S_XFER_WR: begin
          out_count     <= out_count + 1'b1;
          out_top_value <= in_rdata.value;
          out_top_min   <= xfer_min;
          state         <= (in_count == '0) ? S_FRONT : S_XFER_RD;
        end
        S_FRONT: begin
          front         <= out_top_value;
          result_status <= mqts_pkg::STATUS_OK;
          if (pop_now) begin
            out_count <= out_dec;
            state     <= out_re ? S_RELOAD : S_FINISH;
          end else begin
            state <= S_FINISH;
          end
        end
        S_RELOAD: begin
          out_top_value <= out_rdata.value;
          out_top_min   <= out_rdata.minimum;
          state         <= S_FINISH;
        end
        S_FINISH: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            front_value   <= front;
            queue_minimum <= min_now;
            entry_count   <= mqts_pkg::COUNT_W'(total);
            is_empty      <= (total == '0);
            status        <= result_status;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `include "min_queue_two_stacks_top_assert.svh"

  `MQTS_ASSERT_NOW(a_in_bound, 1'b1, in_count <= mqts_pkg::CNT_W'(mqts_pkg::STACK_DEPTH), "in overflow")
  `MQTS_ASSERT_NOW(a_out_room, out_we, out_count < mqts_pkg::CNT_W'(mqts_pkg::STACK_DEPTH), "out overflow")
  `MQTS_ASSERT_NOW(a_xfer_src, state == S_XFER_RD, in_count != '0, "transfer from empty stack")
  `MQTS_ASSERT_NEXT(a_xfer_pair, state == S_XFER_RD, state == S_XFER_WR, "transfer read alone")
  `MQTS_ASSERT_NEXT(a_accept_busy, in_fire, state != S_IDLE, "accepted beat left no work")

endmodule

`default_nettype wire

// ===== rtl/core/mqts_ram.sv =====
// ----------------------------------------------------------------------------
// mqts_ram
// Simple dual-port synchronous RAM with one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mqts_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
